// File: hdl/triangle_min_path_sum_top_defines.svh
`ifndef TRIANGLE_MIN_PATH_SUM_TOP_DEFINES_SVH
`define TRIANGLE_MIN_PATH_SUM_TOP_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define TMPS_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// An antecedent that must be followed by a consequent in the next cycle.
`define TMPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/tmps_pkg.sv
package tmps_pkg;

    // Defaults for the top-level parameters.
    localparam int MAX_ROWS_DEF    = 64;
    localparam int VALUE_WIDTH_DEF = 16;

    // Fixed field widths.
    localparam int CFG_W = 7;
    localparam int OUT_W = 22;

    // Row count after reset.
    localparam logic [CFG_W-1:0] ROW_COUNT_RESET = 7'd1;

    // Depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;

    // Position of one entry within its triangle, worked out by the front.
    typedef struct packed {
        logic row_zero;   // entry belongs to the top row
        logic col_zero;   // first entry of its row
        logic col_last;   // last entry of its row
        logic last_row;   // entry belongs to the last row in use
    } t_entry_flags;

    localparam int FLAGS_W = $bits(t_entry_flags);

endpackage

// File: hdl/triangle_min_path_sum_top.sv
// Triangle minimum path sum engine.
// The input channel (i_in_valid / o_in_ready / i_entry_value) takes one triangle entry per
// beat, row by row from the top, where row r carries r+1 entries. The output channel
// (o_out_valid / i_out_ready / o_min_path_total) delivers one beat per triangle: the
// minimum top-to-bottom path sum, produced when the last entry of the last row arrives.
// The row count is written through i_cfg_we / i_cfg_wdata, by the user only while the
// engine is idle, which the engine does not enforce; zero counts as one row and values
// above MAX_ROWS count as MAX_ROWS. Throughput is one entry per cycle while results are
// taken: each entry needs one read, one add and compare, and one write of the single-row
// partial-sum RAM, and the execute stage retires one entry a cycle. A final entry's result
// passes from the queue write and RAM read to execute and then into the output register.
// Reset clears the row and column counters, the queue and the output valid flag and
// sets the row count to one; o_in_ready is held low while reset is applied. The partial-sum
// RAM is not cleared since every column is written in the top rows before it is read.
// When the receiver stalls, the result waits in the output register; entries that make
// no result keep flowing until the next final entry reaches the execute stage, then the
// four-deep queue fills and o_in_ready drops until the result is taken.
module triangle_min_path_sum_top #(
    parameter int MAX_ROWS    = tmps_pkg::MAX_ROWS_DEF,
    parameter int VALUE_WIDTH = tmps_pkg::VALUE_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [tmps_pkg::CFG_W-1:0]         i_cfg_wdata,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic signed [VALUE_WIDTH-1:0]      i_entry_value,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [tmps_pkg::OUT_W-1:0]  o_min_path_total
);

    localparam int COL_W = $clog2(MAX_ROWS);
    localparam int Q_W   = tmps_pkg::FLAGS_W + VALUE_WIDTH + COL_W;

    // Front side of the queue.
    logic                          push;
    logic                          q_full;
    tmps_pkg::t_entry_flags        f_flags;
    logic [COL_W-1:0]              f_col;
    logic signed [VALUE_WIDTH-1:0] f_value;

    // Back side of the queue.
    logic                          q_valid;
    logic                          q_pop;
    logic [Q_W-1:0]                q_dout;
    tmps_pkg::t_entry_flags        b_flags;
    logic [COL_W-1:0]              b_col;
    logic signed [VALUE_WIDTH-1:0] b_value;

    tmps_front #(
        .MAX_ROWS    (MAX_ROWS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_entry_value (i_entry_value),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_flags       (f_flags),
        .o_col         (f_col),
        .o_value       (f_value)
    );

    tmps_queue #(
        .WIDTH (Q_W),
        .DEPTH (tmps_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_din   ({f_flags, f_value, f_col}),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_dout  (q_dout)
    );

    assign b_flags = tmps_pkg::t_entry_flags'(q_dout[Q_W-1 -: tmps_pkg::FLAGS_W]);
    assign b_value = $signed(q_dout[COL_W +: VALUE_WIDTH]);
    assign b_col   = q_dout[COL_W-1:0];

    tmps_back #(
        .MAX_ROWS    (MAX_ROWS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_valid        (q_valid),
        .i_q_flags        (b_flags),
        .i_q_col          (b_col),
        .i_q_value        (b_value),
        .o_q_pop          (q_pop),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_min_path_total (o_min_path_total)
    );

endmodule

// File: hdl/tmps_ram.sv
module tmps_ram #(
    parameter int WIDTH = 22,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read returns the old contents when the same address is written.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/tmps_queue.sv
`include "triangle_min_path_sum_top_defines.svh"

module tmps_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = tmps_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_din,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_dout
);

    localparam int PW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wptr, n_wptr;
    logic [PW-1:0]    r_rptr, n_rptr;
    logic [PW:0]      r_count, n_count;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_din;
        end
    end

    assign o_full  = (r_count == (PW+1)'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_dout  = r_mem[r_rptr];

    `TMPS_ASSERT_ALWAYS(a_no_push_full, !(i_push && o_full), "queue pushed while full")
    `TMPS_ASSERT_ALWAYS(a_no_pop_empty, !(i_pop && !o_valid), "queue popped while empty")
    `TMPS_ASSERT_ALWAYS(a_count_range, r_count <= (PW+1)'(DEPTH), "queue count out of range")

endmodule

// File: hdl/tmps_front.sv
module tmps_front #(
    parameter int MAX_ROWS    = tmps_pkg::MAX_ROWS_DEF,
    parameter int VALUE_WIDTH = tmps_pkg::VALUE_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [tmps_pkg::CFG_W-1:0]      i_cfg_wdata,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic signed [VALUE_WIDTH-1:0]   i_entry_value,
    input  logic                            i_q_full,
    output logic                            o_push,
    output tmps_pkg::t_entry_flags          o_flags,
    output logic [$clog2(MAX_ROWS)-1:0]     o_col,
    output logic signed [VALUE_WIDTH-1:0]   o_value
);

    localparam int COL_W = $clog2(MAX_ROWS);
    // Wide enough for both the register value and MAX_ROWS itself.
    localparam int CW = (COL_W + 1 > tmps_pkg::CFG_W) ? COL_W + 1 : tmps_pkg::CFG_W;

    logic [tmps_pkg::CFG_W-1:0] r_row_count;
    logic [COL_W-1:0]           r_row, n_row;
    logic [COL_W-1:0]           r_col, n_col;
    logic [CW-1:0]              rows_eff;
    logic [CW-1:0]              cfg_ext;
    tmps_pkg::t_entry_flags     flags;
    logic                       accept;

    assign cfg_ext = CW'(r_row_count);

    always_comb begin
        if (r_row_count == '0) begin
            rows_eff = CW'(1);
        end else if (cfg_ext > CW'(MAX_ROWS)) begin
            rows_eff = CW'(MAX_ROWS);
        end else begin
            rows_eff = cfg_ext;
        end
    end

    always_comb begin
        flags.row_zero = (r_row == '0);
        flags.col_zero = (r_col == '0);
        flags.col_last = (r_col == r_row);
        flags.last_row = ((CW'(r_row) + 1'b1) >= rows_eff);
    end

    // No beat is taken while reset is applied.
    assign o_in_ready = i_rst_n && !i_q_full;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_row = r_row;
        n_col = r_col;
        if (accept) begin
            if (!flags.col_last) begin
                n_col = r_col + 1'b1;
            end else begin
                n_col = '0;
                n_row = flags.last_row ? '0 : r_row + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= tmps_pkg::ROW_COUNT_RESET;
            r_row       <= '0;
            r_col       <= '0;
        end else begin
            if (i_cfg_we) begin
                r_row_count <= i_cfg_wdata;
            end
            r_row <= n_row;
            r_col <= n_col;
        end
    end

    assign o_push  = accept;
    assign o_flags = flags;
    assign o_col   = r_col;
    assign o_value = i_entry_value;

endmodule

// File: hdl/tmps_back.sv
`include "triangle_min_path_sum_top_defines.svh"

module tmps_back #(
    parameter int MAX_ROWS    = tmps_pkg::MAX_ROWS_DEF,
    parameter int VALUE_WIDTH = tmps_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_q_valid,
    input  tmps_pkg::t_entry_flags              i_q_flags,
    input  logic [$clog2(MAX_ROWS)-1:0]         i_q_col,
    input  logic signed [VALUE_WIDTH-1:0]       i_q_value,
    output logic                                o_q_pop,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [tmps_pkg::OUT_W-1:0]   o_min_path_total
);

    localparam int COL_W = $clog2(MAX_ROWS);
    localparam int SUM_W = VALUE_WIDTH + COL_W;
    localparam int OUT_W = tmps_pkg::OUT_W;
    localparam int EXT_W = (SUM_W > OUT_W) ? SUM_W : OUT_W;
    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [EXT_W-1:0] SAT_HI  =
        {{(EXT_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
    localparam logic signed [EXT_W-1:0] SAT_LO  =
        {{(EXT_W-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};

    // Execute stage.
    logic                          r_s1_valid;
    tmps_pkg::t_entry_flags        r_s1_flags;
    logic [COL_W-1:0]              r_s1_col;
    logic signed [VALUE_WIDTH-1:0] r_s1_value;
    logic                          r_fwd_hit;
    logic signed [SUM_W-1:0]       r_fwd_data;

    logic signed [SUM_W-1:0]       r_left_old;
    logic signed [SUM_W-1:0]       r_min;
    logic                          r_out_valid;
    logic signed [OUT_W-1:0]       r_out_total;

    logic [SUM_W-1:0]              ram_rdata;
    logic signed [SUM_W-1:0]       mem_old;
    logic signed [SUM_W-1:0]       old_here;
    logic signed [SUM_W-1:0]       best;
    logic signed [SUM_W-1:0]       v_ext;
    logic signed [SUM_W-1:0]       fresh;
    logic signed [SUM_W-1:0]       next_min;
    logic signed [EXT_W-1:0]       min_ext;
    logic signed [OUT_W-1:0]       sat_total;
    logic                          s1_done;
    logic                          s1_fire;
    logic                          pop;

    tmps_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_ROWS)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (s1_fire),
        .i_waddr (r_s1_col),
        .i_wdata (fresh),
        .i_re    (pop),
        .i_raddr (i_q_col),
        .o_rdata (ram_rdata)
    );

    assign mem_old  = r_fwd_hit ? r_fwd_data : $signed(ram_rdata);
    assign old_here = r_s1_flags.col_last ? '0 : mem_old;
    assign v_ext    = SUM_W'(r_s1_value);

    always_comb begin
        if (r_s1_flags.col_zero) begin
            best = old_here;
        end else if (r_s1_flags.col_last) begin
            best = r_left_old;
        end else begin
            best = (r_left_old < old_here) ? r_left_old : old_here;
        end
    end

    assign fresh    = r_s1_flags.row_zero ? v_ext : v_ext + best;
    assign next_min = (r_s1_flags.col_zero || fresh < r_min) ? fresh : r_min;
    assign min_ext  = EXT_W'(next_min);

    always_comb begin
        if (min_ext > SAT_HI) begin
            sat_total = OUT_W'(SAT_HI);
        end else if (min_ext < SAT_LO) begin
            sat_total = OUT_W'(SAT_LO);
        end else begin
            sat_total = OUT_W'(min_ext);
        end
    end

    assign s1_done = r_s1_flags.last_row && r_s1_flags.col_last;
    assign s1_fire = r_s1_valid && (!s1_done || !r_out_valid || i_out_ready);
    assign pop     = i_q_valid && (!r_s1_valid || s1_fire);
    assign o_q_pop = pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_left_old  <= '0;
            r_min       <= SUM_MAX;
        end else begin
            if (pop) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end

            if (s1_fire && s1_done) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (s1_fire) begin
                if (r_s1_flags.col_last) begin
                    r_left_old <= '0;
                end else if (!r_s1_flags.row_zero) begin
                    r_left_old <= old_here;
                end
                if (s1_done) begin
                    r_min <= SUM_MAX;
                end else if (r_s1_flags.last_row) begin
                    r_min <= next_min;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_s1_flags <= i_q_flags;
            r_s1_col   <= i_q_col;
            r_s1_value <= i_q_value;
            // The RAM returns old data when the retiring entry writes the same column.
            r_fwd_hit  <= s1_fire && (r_s1_col == i_q_col);
            r_fwd_data <= fresh;
        end
        if (s1_fire && s1_done) begin
            r_out_total <= sat_total;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_min_path_total = r_out_total;

    `TMPS_ASSERT_ALWAYS(a_pop_needs_slot, !pop || !r_s1_valid || s1_fire, "execute stage overrun")
    `TMPS_ASSERT_ALWAYS(a_result_has_room,
        !(s1_fire && s1_done) || !r_out_valid || i_out_ready, "result register overwritten")
    `TMPS_ASSERT_NEXT(a_fwd_only_on_hit, pop && !s1_fire, !r_fwd_hit, "stale forward flag")

endmodule

// File: bench/triangle_min_path_sum_top_tb.sv
`timescale 1ns / 100ps

module triangle_min_path_sum_top_tb;

    localparam int VW            = tmps_pkg::VALUE_WIDTH_DEF;
    localparam int ROWS_MAX      = tmps_pkg::MAX_ROWS_DEF;
    localparam int OUT_W         = tmps_pkg::OUT_W;
    localparam int CFG_W         = tmps_pkg::CFG_W;
    localparam longint TOTAL_HI  = (longint'(1) << (OUT_W - 1)) - 1;
    localparam longint TOTAL_LO  = -(longint'(1) << (OUT_W - 1));
    localparam longint SUM_CEIL  = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam int MAX_WAIT      = 12;
    // A final entry's result passes through the queue and the execute stage, and the
    // queue may still hold up to four entries that make no result.
    localparam int SETTLE_CYCLES = 12;
    localparam int RANDOM_BEATS  = 380;
    localparam int MAX_REPORTS   = 10;
    localparam int unsigned CYCLE_LIMIT = 600000;

    localparam logic signed [VW-1:0] VALUE_HI = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW-1:0] VALUE_LO = {1'b1, {(VW-1){1'b0}}};

    typedef enum int {FILL_RANDOM, FILL_HIGH, FILL_LOW} t_fill_kind;

    // Tracks the engine's row of partial sums and holds the totals that are
    // still due on the output.
    class path_sum_scoreboard;
        longint row_sums[ROWS_MAX];
        int unsigned row_pos;
        int unsigned col_pos;
        longint left_above;
        longint row_min;
        logic [CFG_W-1:0] rows_setting;
        logic signed [OUT_W-1:0] totals_due[$];
        int fault_count;

        function new();
            foreach (row_sums[i]) row_sums[i] = 0;
            row_pos      = 0;
            col_pos      = 0;
            left_above   = 0;
            row_min      = SUM_CEIL;
            rows_setting = tmps_pkg::ROW_COUNT_RESET;
            fault_count  = 0;
        endfunction

        function void set_row_count(logic [CFG_W-1:0] value);
            rows_setting = value;
        endfunction

        function void note_fault(string msg);
            fault_count++;
            if (fault_count <= MAX_REPORTS) begin
                $display("%0t: %s", $realtime, msg);
            end
        endfunction

        // Folds one accepted entry into the row and queues a total when the
        // entry closes the last row in use.
        function void note_entry(logic signed [VW-1:0] value);
            int unsigned r;
            int unsigned c;
            int unsigned rows;
            bit last_row;
            longint above;
            longint best;
            longint fresh;
            longint total;
            r = row_pos;
            c = col_pos;
            if (rows_setting == 0) begin
                rows = 1;
            end else if (rows_setting > ROWS_MAX) begin
                rows = ROWS_MAX;
            end else begin
                rows = 32'(rows_setting);
            end
            last_row = (r + 1 >= rows);
            if (r == 0) begin
                fresh = longint'(value);
            end else begin
                above = (c < r) ? row_sums[c] : 0;
                if (c == 0) begin
                    best = above;
                end else if (c == r) begin
                    best = left_above;
                end else begin
                    best = (left_above < above) ? left_above : above;
                end
                // The old sum of this column is the left neighbor of the next one.
                left_above = above;
                fresh = longint'(value) + best;
            end
            row_sums[c] = fresh;
            if (last_row && (c == 0 || fresh < row_min)) begin
                row_min = fresh;
            end
            if (c < r) begin
                col_pos = c + 1;
                return;
            end
            col_pos    = 0;
            left_above = 0;
            if (last_row) begin
                total = row_min;
                if (total > TOTAL_HI) total = TOTAL_HI;
                if (total < TOTAL_LO) total = TOTAL_LO;
                totals_due.push_back(total[OUT_W-1:0]);
                row_pos = 0;
                row_min = SUM_CEIL;
            end else begin
                row_pos = r + 1;
            end
        endfunction

        function void check_total(logic signed [OUT_W-1:0] seen);
            logic signed [OUT_W-1:0] want;
            if (totals_due.size() == 0) begin
                note_fault($sformatf("unexpected min_path_total %0d", seen));
            end else begin
                want = totals_due.pop_front();
                if (seen !== want) begin
                    note_fault($sformatf("min_path_total mismatch: expected %0d, got %0d",
                        want, seen));
                end
            end
        endfunction

        function int pending();
            return totals_due.size();
        endfunction

        function bit clean();
            return (fault_count == 0) && (totals_due.size() == 0);
        endfunction
    endclass

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_we = 1'b0;
    logic [CFG_W-1:0]         i_cfg_wdata = '0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_ready;
    logic signed [VW-1:0]     i_entry_value = '0;
    logic                     o_out_valid;
    logic                     i_out_ready = 1'b0;
    logic signed [OUT_W-1:0]  o_min_path_total;

    path_sum_scoreboard sb = new();

    // When set, the sender or the receiver runs without waiting between beats.
    bit in_quiet = 1'b0;
    bit out_quiet = 1'b0;
    int unsigned cycle_count = 0;

    triangle_min_path_sum_top DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_entry_value    (i_entry_value),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_min_path_total (o_min_path_total)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // The run is cut off if it hangs anywhere.
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    // The receiver takes result beats for the whole run once reset is over.
    // Ready stays high from one beat to the next when no wait is drawn, so it
    // is never lowered and raised again at the same edge.
    initial begin
        int gap;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            gap = out_quiet ? 0 : $urandom_range(0, MAX_WAIT);
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            sb.check_total(o_min_path_total);
        end
    end

    // Sends one entry beat. Valid is held from the previous beat when no wait
    // is drawn. The scoreboard sees the entry at the edge where it is accepted.
    task automatic send_entry(input logic signed [VW-1:0] value);
        int gap;
        gap = in_quiet ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_entry_value <= value;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        sb.note_entry(value);
    endtask

    // Random entries favor the extremes and small values. Small values make
    // ties between the two upper neighbors likely.
    function automatic logic signed [VW-1:0] draw_entry(t_fill_kind fill);
        case (fill)
            FILL_HIGH: return VALUE_HI;
            FILL_LOW:  return VALUE_LO;
            default: begin
                case ($urandom_range(0, 9))
                    0: return VALUE_LO;
                    1: return VALUE_HI;
                    2, 3: return VW'($urandom_range(0, 8)) - VW'(4);
                    default: return VW'($urandom);
                endcase
            end
        endcase
    endfunction

    task automatic send_entries(input int count, input t_fill_kind fill);
        repeat (count) send_entry(draw_entry(fill));
    endtask

    // Waits until every queued total has come out. Then it waits for entries
    // that make no total to leave the pipeline, so that the engine is idle.
    task automatic settle_block();
        i_in_valid <= 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_row_count(input logic [CFG_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.set_row_count(value);
    endtask

    function automatic int triangle_beats(logic [CFG_W-1:0] rows);
        int n;
        n = (rows == 0) ? 1 : ((rows > ROWS_MAX) ? ROWS_MAX : int'(rows));
        return n * (n + 1) / 2;
    endfunction

    initial begin
        int sent;
        int size;
        int count;
        logic [CFG_W-1:0] rows;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // One row after reset means every entry is a whole triangle on its
        // own, so both extremes and the alternating bit patterns come back
        // unchanged.
        send_entry(VALUE_LO);
        send_entry(VALUE_HI);
        send_entry('0);
        send_entry(VW'(-1));
        send_entry(VW'(1));
        send_entry(16'sh5555);
        send_entry(16'shAAAA);

        // A row count of zero behaves as one row.
        settle_block();
        write_row_count('0);
        send_entry(VW'(-7));
        send_entry(VW'(9));

        // Three rows give both edge columns and a middle column. The middle
        // column sees equal neighbors, and the last row has equal sums at both
        // edges.
        settle_block();
        write_row_count(7'd3);
        send_entry('0);
        send_entry(VW'(1));
        send_entry(VW'(1));
        send_entry(VW'(7));
        send_entry(VW'(-4));
        send_entry(VW'(7));

        // The count is lowered in the middle of a triangle: the engine stops
        // at the third row of four, and a count of two then closes that row
        // as the last one.
        settle_block();
        write_row_count(7'd4);
        send_entry(VW'(2));
        send_entry(VW'(-3));
        send_entry(VW'(5));
        send_entry(VW'(4));
        settle_block();
        write_row_count(7'd2);
        send_entry(VW'(-6));
        send_entry(VW'(1));

        // Taller triangles of all largest and then all smallest values.
        settle_block();
        write_row_count(7'd12);
        send_entries(triangle_beats(7'd12), FILL_HIGH);
        settle_block();
        write_row_count(7'd12);
        send_entries(triangle_beats(7'd12), FILL_LOW);

        // The count is set just above the maximum and the engine stops deep
        // inside the triangle. The first random phase then changes the count.
        settle_block();
        write_row_count(7'(ROWS_MAX + 1));
        send_entries(40, FILL_RANDOM);

        // Random phases mostly use small triangles. Some phases stop in the
        // middle of a triangle, and the next count applies to the rest of it.
        sent = 0;
        while (sent < RANDOM_BEATS) begin
            settle_block();
            case ($urandom_range(0, 11))
                0: rows = '0;
                1, 2: rows = 7'($urandom_range(9, 20));
                default: rows = 7'($urandom_range(1, 8));
            endcase
            write_row_count(rows);
            in_quiet  = ($urandom_range(0, 3) == 0);
            out_quiet = ($urandom_range(0, 3) == 0);
            size = triangle_beats(rows);
            if ($urandom_range(0, 3) == 0) begin
                count = $urandom_range(1, size);
            end else begin
                count = size * $urandom_range(1, 3);
            end
            if (count > RANDOM_BEATS - sent) begin
                count = RANDOM_BEATS - sent;
            end
            send_entries(count, FILL_RANDOM);
            sent += count;
        end

        settle_block();
        if (sb.clean()) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
